[sv/ftacc_pkg.sv]
// ----------------------------------------------------------------------------
// ftacc_pkg: shared definitions for the fixed timestep accumulator
// Field widths, reset values, controller codes and the count saturation helper.
// ----------------------------------------------------------------------------
package ftacc_pkg;

  localparam int DtW          = 24;
  localparam int StepW        = 20;
  localparam int FrameW       = 22;
  localparam int CarryW       = 32;
  localparam int SumW         = 33;
  localparam int CountW       = 16;
  localparam int OutTimeW     = 48;
  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = 22;
  localparam int IterW        = 6;
  localparam int TimeWidthDef = 48;

  localparam logic [StepW-1:0]  StepResetVal  = 20'd10000;
  localparam logic [FrameW-1:0] FrameResetVal = 22'd500000;
  localparam logic [IterW-1:0]  DropIters     = IterW'(SumW);
  localparam logic [IterW-1:0]  StepIters     = IterW'(FrameW);
  localparam logic [CountW-1:0] CountMax      = '1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_STEP  = 2'd0,
    CFG_MAX_FRAME = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_CHECK,
    ST_DROP,
    ST_STEP_GO,
    ST_STEP,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic clamp;
    logic check;
    logic drop_done;
    logic step_start;
    logic step_done;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_drop;
    logic div_done;
    logic out_stall;
  } ctrl_status_t;

  // Clamp a wide count to the 16-bit reported range.
  function automatic logic [CountW-1:0] sat_count(input logic [SumW-1:0] v);
    return (v > SumW'(CountMax)) ? CountMax : v[CountW-1:0];
  endfunction

endpackage

[sv/ftacc_channels.sv]
// ----------------------------------------------------------------------------
// ftacc channels: valid/ready interfaces of the fixed timestep accumulator
// Input frame channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface ftacc_in_if import ftacc_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [DtW-1:0] frame_dt_us;

  modport source (output valid, output frame_dt_us, input ready);
  modport sink (input valid, input frame_dt_us, output ready);
  modport monitor (input valid, input frame_dt_us, input ready);
endinterface

interface ftacc_out_if import ftacc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CountW-1:0]   substep_count;
  logic [CountW-1:0]   dropped_frames;
  logic [OutTimeW-1:0] world_time_us;
  logic [OutTimeW-1:0] real_time_us;

  modport source (output valid, output substep_count, output dropped_frames,
                  output world_time_us, output real_time_us, input ready);
  modport sink (input valid, input substep_count, input dropped_frames,
                input world_time_us, input real_time_us, output ready);
  modport monitor (input valid, input substep_count, input dropped_frames,
                   input world_time_us, input real_time_us, input ready);
endinterface

interface ftacc_cfg_if import ftacc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
  modport monitor (input valid, input index, input data, input ready);
endinterface

[sv/fixed_timestep_accumulator.sv]
// ----------------------------------------------------------------------------
// fixed_timestep_accumulator: frame delta to fixed substep scheduler
// Turns each rendered frame's delta into a substep count and updated clocks.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one frame delta in microseconds per beat. out_o returns one
//   beat per input with the substep count, the dropped backlog frames and the
//   world and real clocks after that frame. cfg_i writes the substep length
//   (index 0) and the maximum frame (index 1); it is always ready and must
//   only be used while no frame is in flight.
// Sequencing:
//   One frame is in work at a time, and the next frame is taken in the cycle
//   after its result beat is registered. The shared one-bit-per-cycle divider
//   runs the backlog drop, when there is one, and then the substep split.
// Reset:
//   The clocks and the carry clear, the registers return to 10 ms substeps
//   and a 0.5 s maximum frame, and no result is pending.
// Stalls:
//   The result sits in its own register, so a new frame is accepted while
//   the previous beat waits; the next result waits until that one is taken.
// ----------------------------------------------------------------------------
module fixed_timestep_accumulator import ftacc_pkg::*; #(
  parameter int TimeWidth = TimeWidthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ftacc_cfg_if.sink     cfg_i,
  ftacc_in_if.sink      in_i,
  ftacc_out_if.source   out_o
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;
  logic         in_ready;

  // Configuration writes land directly in the datapath registers.
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;

  ftacc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the clocks, the carry, the divider and the result beat.
  ftacc_dp #(
    .TimeWidth (TimeWidth)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_i.valid),
    .cfg_idx_i        (cfg_i.index),
    .cfg_data_i       (cfg_i.data),
    .dt_i             (in_i.frame_dt_us),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .substep_count_o  (out_o.substep_count),
    .dropped_frames_o (out_o.dropped_frames),
    .world_time_us_o  (out_o.world_time_us),
    .real_time_us_o   (out_o.real_time_us)
  );

endmodule

[sv/ftacc_div.sv]
// ----------------------------------------------------------------------------
// ftacc_div: shared iterative restoring divider
// One quotient bit per cycle; the dividend arrives left aligned.
// ----------------------------------------------------------------------------
module ftacc_div import ftacc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [IterW-1:0]  iters_i,
  input  logic [SumW-1:0]   dividend_i,
  input  logic [FrameW-1:0] divisor_i,
  output logic              done_o,
  output logic [SumW-1:0]   quot_o,
  output logic [FrameW-1:0] rem_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [IterW-1:0]  cnt_q, cnt_d;
  logic [SumW-1:0]   num_q;
  logic [SumW-1:0]   quot_q;
  logic [FrameW-1:0] rem_q;
  logic [FrameW:0]   shifted;
  logic [FrameW:0]   diff;
  logic              ge;
  logic [FrameW-1:0] rem_next;

  assign shifted  = {rem_q, num_q[SumW-1]};
  assign ge       = (shifted >= {1'b0, divisor_i});
  assign diff     = shifted - {1'b0, divisor_i};
  assign rem_next = ge ? diff[FrameW-1:0] : shifted[FrameW-1:0];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = iters_i;
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == IterW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= dividend_i;
      quot_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      num_q  <= {num_q[SumW-2:0], 1'b0};
      quot_q <= {quot_q[SumW-2:0], ge};
      rem_q  <= rem_next;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

[sv/ftacc_dp.sv]
// ----------------------------------------------------------------------------
// ftacc_dp: datapath of the fixed timestep accumulator
// Clocks, carry, clamp, backlog drop, substep split and the result register.
// ----------------------------------------------------------------------------
module ftacc_dp import ftacc_pkg::*; #(
  parameter int TimeWidth = TimeWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [DtW-1:0]      dt_i,
  input  ctrl_cmd_t           cmd_i,
  output ctrl_status_t        status_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [CountW-1:0]   substep_count_o,
  output logic [CountW-1:0]   dropped_frames_o,
  output logic [OutTimeW-1:0] world_time_us_o,
  output logic [OutTimeW-1:0] real_time_us_o
);

  logic [StepW-1:0]     max_step_q;
  logic [FrameW-1:0]    max_frame_q;
  logic [TimeWidth-1:0] real_q;
  logic [TimeWidth-1:0] world_q;
  logic [CarryW-1:0]    carry_q;
  logic                 out_valid_q;

  logic [SumW-1:0]      sum_q;
  logic [FrameW-1:0]    frame_q;
  logic [SumW-1:0]      excess_q;
  logic [FrameW-1:0]    resid_q;
  logic [CountW-1:0]    dropped_q;
  logic [CountW-1:0]    steps_q;
  logic                 div_step_q;
  logic [CountW-1:0]    out_steps_q;
  logic [CountW-1:0]    out_dropped_q;
  logic [OutTimeW-1:0]  out_world_q;
  logic [OutTimeW-1:0]  out_real_q;

  logic                 frame_zero;
  logic                 step_zero;
  logic                 need_drop;
  logic                 div_start;
  logic [IterW-1:0]     div_iters;
  logic [SumW-1:0]      div_dividend;
  logic [FrameW-1:0]    div_divisor;
  logic                 div_done;
  logic [SumW-1:0]      div_quot;
  logic [FrameW-1:0]    div_rem;
  logic [FrameW-1:0]    step_rem;
  logic [FrameW-1:0]    step_span;
  logic [63:0]          world_wide;
  logic [63:0]          real_wide;

  assign frame_zero = (max_frame_q == '0);
  assign step_zero  = (max_step_q == '0);
  assign need_drop  = !frame_zero && (excess_q > SumW'(max_frame_q));

  // The divider serves the backlog drop first and the substep split second.
  assign div_start    = (cmd_i.check && need_drop) || cmd_i.step_start;
  assign div_iters    = cmd_i.step_start ? StepIters : DropIters;
  assign div_dividend = cmd_i.step_start ? {frame_q, {(SumW-FrameW){1'b0}}}
                                         : (excess_q - SumW'(1));
  assign div_divisor  = div_step_q ? FrameW'(max_step_q) : max_frame_q;

  ftacc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .iters_i    (div_iters),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // A zero substep length runs no substeps and leaves the whole frame over.
  assign step_rem  = step_zero ? frame_q : div_rem;
  assign step_span = frame_q - step_rem;

  assign world_wide = 64'(world_q);
  assign real_wide  = 64'(real_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_step_q  <= StepResetVal;
      max_frame_q <= FrameResetVal;
      real_q      <= '0;
      world_q     <= '0;
      carry_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MAX_STEP:  max_step_q  <= cfg_data_i[StepW-1:0];
          CFG_MAX_FRAME: max_frame_q <= cfg_data_i[FrameW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        real_q <= real_q + TimeWidth'(dt_i);
      end
      if (cmd_i.step_done) begin
        world_q <= world_q + TimeWidth'(step_span);
        carry_q <= CarryW'({1'b0, resid_q} + {1'b0, step_rem});
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sum_q <= SumW'(dt_i) + SumW'(carry_q);
    end
    if (cmd_i.clamp) begin
      if (sum_q > SumW'(max_frame_q)) begin
        excess_q <= sum_q - SumW'(max_frame_q);
        frame_q  <= max_frame_q;
      end else begin
        excess_q <= '0;
        frame_q  <= sum_q[FrameW-1:0];
      end
    end
    if (cmd_i.check) begin
      if (frame_zero) begin
        dropped_q <= (excess_q != '0) ? CountMax : '0;
        resid_q   <= '0;
      end else if (!need_drop) begin
        dropped_q <= '0;
        resid_q   <= excess_q[FrameW-1:0];
      end
    end
    if (div_start) begin
      div_step_q <= cmd_i.step_start;
    end
    if (cmd_i.drop_done) begin
      dropped_q <= sat_count(div_quot);
      resid_q   <= div_rem + FrameW'(1);
    end
    if (cmd_i.step_done) begin
      steps_q <= step_zero ? '0 : sat_count(div_quot);
    end
    if (cmd_i.emit) begin
      out_steps_q   <= steps_q;
      out_dropped_q <= dropped_q;
      out_world_q   <= world_wide[OutTimeW-1:0];
      out_real_q    <= real_wide[OutTimeW-1:0];
    end
  end

  assign status_o.need_drop = need_drop;
  assign status_o.div_done  = div_done;
  assign status_o.out_stall = out_valid_q && !out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign substep_count_o  = out_steps_q;
  assign dropped_frames_o = out_dropped_q;
  assign world_time_us_o  = out_world_q;
  assign real_time_us_o   = out_real_q;

endmodule

[sv/ftacc_ctrl.sv]
// ----------------------------------------------------------------------------
// ftacc_ctrl: sequencing controller of the fixed timestep accumulator
// Walks one frame through clamp, backlog drop, substep split and result.
// ----------------------------------------------------------------------------
module ftacc_ctrl import ftacc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  ctrl_status_t status_i,
  output ctrl_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        cmd_o.clamp = 1'b1;
        state_d     = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = status_i.need_drop ? ST_DROP : ST_STEP_GO;
      end
      ST_DROP: begin
        if (status_i.div_done) begin
          cmd_o.drop_done = 1'b1;
          state_d         = ST_STEP_GO;
        end
      end
      ST_STEP_GO: begin
        cmd_o.step_start = 1'b1;
        state_d          = ST_STEP;
      end
      ST_STEP: begin
        if (status_i.div_done) begin
          cmd_o.step_done = 1'b1;
          state_d         = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!status_i.out_stall) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[sv/ftacc_checker.sv]
// ----------------------------------------------------------------------------
// ftacc_checker: port level checks of the fixed timestep accumulator
// Watches the channels over time and is bound to the top level.
// ----------------------------------------------------------------------------
module ftacc_checker import ftacc_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  ftacc_cfg_if.sink   cfg_i,
  ftacc_in_if.sink    in_i,
  ftacc_out_if.source out_o
);

  // A result beat stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid)
    else $error("result beat withdrawn before it was taken");

  // Configuration writes are never stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_i.ready)
    else $error("configuration channel not ready");

  // Frames are worked one at a time; the clamp and drop check follow acceptance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready ##1 !in_i.ready ##1 !in_i.ready)
    else $error("new frame accepted while one is still in work");

  // A result cannot appear in the cycle right after a frame is accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !$rose(out_o.valid))
    else $error("result beat appeared too early");

endmodule

bind fixed_timestep_accumulator ftacc_checker u_ftacc_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .cfg_i  (cfg_i),
  .in_i   (in_i),
  .out_o  (out_o)
);

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the fixed timestep accumulator
// Feeds frame deltas and register writes under random idling on both sides.
// It predicts every result beat in a local model of the substep scheduler
// and compares the beats field by field as they come out.
// ----------------------------------------------------------------------------
module testbench;
  import ftacc_pkg::*;

  // Spare register indexes. Writes to them must leave both registers alone.
  localparam logic [CfgIdxW-1:0] CfgIdxSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareHi = 2'd3;

  // Worst case per frame is the work of a frame with backlog to drop, a full
  // sender gap and a full receiver stall, for each of about 1900 frames. The
  // limit leaves a factor of five on top of that.
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned RandomItems = 1850;
  localparam int unsigned MaxIdle     = 18;
  // Longest time from acceptance to the result beat, with backlog to drop.
  localparam int unsigned TailCycles  = 64;

  typedef struct packed {
    logic [CountW-1:0]   substeps;
    logic [CountW-1:0]   dropped;
    logic [OutTimeW-1:0] world_us;
    logic [OutTimeW-1:0] real_us;
  } frame_result_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } reg_write_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #1 clk_i = ~clk_i;

  ftacc_cfg_if cfg_if ();
  ftacc_in_if  in_if ();
  ftacc_out_if out_if ();

  fixed_timestep_accumulator uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Local copy of the scheduler state and of both registers.
  logic [StepW-1:0]    step_len  = StepResetVal;
  logic [FrameW-1:0]   frame_len = FrameResetVal;
  logic [CarryW-1:0]   carry_us  = '0;
  logic [OutTimeW-1:0] real_clk  = '0;
  logic [OutTimeW-1:0] world_clk = '0;

  // Results still owed by the block, oldest first.
  frame_result_t predicted_frames[$];
  // Register writes collected for the next programming burst.
  reg_write_t    pending_writes[$];

  int unsigned cycles       = 0;
  int unsigned mismatches   = 0;
  int unsigned frames_sent  = 0;
  int unsigned results_seen = 0;
  int unsigned reg_writes   = 0;
  int unsigned timing_sets  = 0;
  int unsigned random_sent  = 0;

  // While a side is quiet it does not idle at all; each side flips its mode
  // now and then so that long back-to-back stretches also occur.
  bit src_quiet  = 1'b0;
  bit sink_quiet = 1'b0;

  always @(posedge clk_i) cycles <= cycles + 1;

  // Advances the local scheduler by one frame delta and returns the beat that
  // the block must produce for it.
  function automatic frame_result_t schedule_frame(input logic [DtW-1:0] dt);
    logic [63:0]   sum;
    logic [63:0]   span;
    logic [63:0]   excess;
    logic [63:0]   drops;
    logic [63:0]   steps;
    frame_result_t res;
    real_clk = real_clk + OutTimeW'(dt);
    sum = 64'(dt) + 64'(carry_us);
    // Clamp the frame. Without a clamp there is no excess and the whole sum is the span.
    if (sum > 64'(frame_len)) begin
      excess = sum - 64'(frame_len);
      span   = 64'(frame_len);
    end else begin
      excess = '0;
      span   = sum;
    end
    // Throw away whole maximum frames of backlog. A zero maximum frame throws
    // away all of it and reports a saturated count if there was any.
    drops = '0;
    if (frame_len == '0) begin
      if (excess != '0) drops = 64'(CountMax);
      excess = '0;
    end else if (excess > 64'(frame_len)) begin
      drops  = (excess - 64'd1) / 64'(frame_len);
      excess = excess - drops * 64'(frame_len);
    end
    // Split into whole substeps. A zero substep length runs none and leaves
    // the whole clamped span in the carry.
    steps = '0;
    if (step_len != '0) begin
      steps     = span / 64'(step_len);
      span      = span - steps * 64'(step_len);
      world_clk = world_clk + OutTimeW'(steps * 64'(step_len));
    end
    carry_us = CarryW'(excess + span);
    // The world clock took every substep; only the reported counts saturate.
    res.substeps = (steps > 64'(CountMax)) ? CountMax : steps[CountW-1:0];
    res.dropped  = (drops > 64'(CountMax)) ? CountMax : drops[CountW-1:0];
    res.world_us = world_clk;
    res.real_us  = real_clk;
    return res;
  endfunction

  // Draws a frame delta around the current timing: near multiples of the
  // substep, up to two maximum frames, the full 24-bit range and both ends.
  function automatic logic [DtW-1:0] pick_frame_dt();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0: begin
        v = 64'($urandom);
      end
      1: begin
        v = ($urandom_range(0, 1) != 0) ? 64'd0 : 64'hFF_FFFF;
      end
      2, 3: begin
        v = 64'($urandom_range(0, 8)) * 64'(step_len) + 64'($urandom_range(0, 2)) - 64'd1;
      end
      default: begin
        v = 64'($urandom_range(0, 2 * 32'(frame_len) + 1));
      end
    endcase
    return DtW'(v);
  endfunction

  // Sends one frame delta. The valid of the previous beat is only lowered when
  // this beat waits first, so a gapless run keeps valid high throughout.
  task automatic send_frame(input logic [DtW-1:0] dt);
    int unsigned gap;
    gap = src_quiet ? 0 : $urandom_range(0, MaxIdle);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.frame_dt_us <= dt;
    do @(posedge clk_i); while (!in_if.ready);
    predicted_frames.push_back(schedule_frame(dt));
    frames_sent++;
    if ($urandom_range(0, 24) == 0) src_quiet = !src_quiet;
  endtask

  // Ends the frame stream and waits until every owed result beat is taken.
  task automatic drain_frames();
    in_if.valid <= 1'b0;
    while (predicted_frames.size() != 0) @(posedge clk_i);
  endtask

  // Writes the collected registers back to back with the block idle.
  task automatic flush_reg_writes();
    reg_write_t w;
    drain_frames();
    while (pending_writes.size() != 0) begin
      w = pending_writes.pop_front();
      cfg_if.valid <= 1'b1;
      cfg_if.index <= w.idx;
      cfg_if.data  <= w.data;
      do @(posedge clk_i); while (!cfg_if.ready);
      case (w.idx)
        CFG_MAX_STEP: begin
          step_len = w.data[StepW-1:0];
        end
        CFG_MAX_FRAME: begin
          frame_len = w.data[FrameW-1:0];
        end
        default: begin
        end
      endcase
      reg_writes++;
    end
    cfg_if.valid <= 1'b0;
    timing_sets++;
  endtask

  task automatic set_timing(input logic [CfgDataW-1:0] step, input logic [CfgDataW-1:0] frame);
    pending_writes.push_back('{idx: CFG_MAX_STEP, data: step});
    pending_writes.push_back('{idx: CFG_MAX_FRAME, data: frame});
    flush_reg_writes();
  endtask

  // Compares one taken result beat with the oldest prediction.
  task automatic check_result();
    frame_result_t got;
    frame_result_t want;
    got.substeps = out_if.substep_count;
    got.dropped  = out_if.dropped_frames;
    got.world_us = out_if.world_time_us;
    got.real_us  = out_if.real_time_us;
    results_seen++;
    if (predicted_frames.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("cycle %0d: result beat with no frame outstanding: steps %0d dropped %0d",
                 cycles, got.substeps, got.dropped);
      end
    end else begin
      want = predicted_frames.pop_front();
      if (got.substeps !== want.substeps || got.dropped !== want.dropped ||
          got.world_us !== want.world_us || got.real_us !== want.real_us) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("cycle %0d: beat %0d mismatch", cycles, results_seen);
          $display("  expected steps %0d dropped %0d world %0d real %0d",
                   want.substeps, want.dropped, want.world_us, want.real_us);
          $display("  actual   steps %0d dropped %0d world %0d real %0d",
                   got.substeps, got.dropped, got.world_us, got.real_us);
        end
      end
    end
  endtask

  // Result side: stalls a random number of cycles before each beat, then
  // holds ready until a beat is taken and checks it at that edge.
  initial begin : result_sink
    int unsigned stall;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = sink_quiet ? 0 : $urandom_range(0, MaxIdle);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      check_result();
      if ($urandom_range(0, 24) == 0) sink_quiet = !sink_quiet;
    end
  end

  // The registers as they come out of reset: frames without a clamp, a frame
  // just over the maximum, and a full-scale delta with a deep backlog.
  task automatic test_reset_defaults();
    send_frame(24'd0);
    send_frame(24'd9999);
    send_frame(24'd10001);
    send_frame(24'd500001);
    send_frame('1);
    send_frame(24'd0);
  endtask

  // Lower and upper ends of the register ranges, then all-ones register data.
  task automatic test_register_extremes();
    set_timing(22'd100, 22'd1000);
    send_frame(24'd150);
    send_frame(24'd2550);
    set_timing(22'd1000000, 22'd4000000);
    send_frame(24'd3999999);
    send_frame(24'd4000001);
    set_timing(22'h0FFFFF, 22'h3FFFFF);
    send_frame(24'h3FFFFF);
    send_frame(24'd0);
  endtask

  // One microsecond substeps overflow the step count; a tiny maximum frame
  // overflows the dropped count. The clocks must still advance in full.
  task automatic test_saturated_counts();
    set_timing(22'd1, 22'h3FFFFF);
    send_frame('1);
    set_timing(22'd100, 22'd100);
    send_frame('1);
  endtask

  // A zero maximum frame discards the whole carry: the first frame still has
  // a carry from before, the second brings fresh time, the third none.
  task automatic test_zero_frame();
    set_timing(22'd100, 22'd0);
    send_frame(24'd0);
    send_frame(24'd12345);
    send_frame(24'd0);
  endtask

  // A zero substep length holds the world clock and piles the clamped time
  // into the carry; a real substep length then spends it.
  task automatic test_zero_step();
    set_timing(22'd0, 22'd5000);
    send_frame(24'd3000);
    send_frame(24'd4000);
    set_timing(22'd1000, 22'd5000);
    send_frame(24'd0);
  endtask

  // Substep data with bits above its 20-bit field, and writes to both spare
  // indexes, which must change nothing.
  task automatic test_spare_indexes();
    pending_writes.push_back('{idx: CFG_MAX_STEP, data: 22'h3FFFFF});
    pending_writes.push_back('{idx: CFG_MAX_FRAME, data: 22'h2AAAAA});
    pending_writes.push_back('{idx: CfgIdxSpareLo, data: CfgDataW'($urandom)});
    pending_writes.push_back('{idx: CfgIdxSpareHi, data: CfgDataW'($urandom)});
    flush_reg_writes();
    send_frame('1);
    send_frame(24'd1);
  endtask

  // Picks a fresh timing setup: mostly in range, sometimes at either end,
  // sometimes below range or with raw 22-bit data, now and then with spare
  // index writes mixed in and the two registers in either order.
  task automatic retune_timing();
    logic [CfgDataW-1:0] step;
    logic [CfgDataW-1:0] frame;
    case ($urandom_range(0, 9))
      0: step = 22'd100;
      1: step = 22'd1000000;
      2: step = CfgDataW'($urandom_range(0, 99));
      3: step = CfgDataW'($urandom);
      default: step = CfgDataW'($urandom_range(100, 1000000));
    endcase
    case ($urandom_range(0, 9))
      0: frame = 22'd1000;
      1: frame = 22'd4000000;
      2: frame = CfgDataW'($urandom_range(0, 999));
      3: frame = CfgDataW'($urandom);
      default: frame = CfgDataW'($urandom_range(1000, 4000000));
    endcase
    if ($urandom_range(0, 3) == 0) begin
      pending_writes.push_back('{idx: CfgIdxSpareLo + CfgIdxW'($urandom_range(0, 1)),
                                 data: CfgDataW'($urandom)});
    end
    if ($urandom_range(0, 1) != 0) begin
      pending_writes.push_back('{idx: CFG_MAX_STEP, data: step});
      pending_writes.push_back('{idx: CFG_MAX_FRAME, data: frame});
    end else begin
      pending_writes.push_back('{idx: CFG_MAX_FRAME, data: frame});
      pending_writes.push_back('{idx: CFG_MAX_STEP, data: step});
    end
    flush_reg_writes();
  endtask

  // Random frame streams, each under its own timing setup.
  task automatic test_random_frames();
    int unsigned run_len;
    while (random_sent < RandomItems) begin
      retune_timing();
      run_len = $urandom_range(20, 60);
      repeat (run_len) begin
        send_frame(pick_frame_dt());
        random_sent++;
      end
    end
  endtask

  initial begin : watchdog
    wait (cycles >= CycleLimit);
    $display("Run stopped at the cycle limit with %0d beats outstanding",
             predicted_frames.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    rst_ni            <= 1'b0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= CFG_MAX_STEP;
    cfg_if.data       <= '0;
    in_if.valid       <= 1'b0;
    in_if.frame_dt_us <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_register_extremes();
    test_saturated_counts();
    test_zero_frame();
    test_zero_step();
    test_spare_indexes();
    test_random_frames();

    // Let the last beats come out, then give a stray beat time to show up.
    drain_frames();
    repeat (TailCycles) @(posedge clk_i);

    $display("Sent %0d frames under %0d timing setups (%0d register writes).",
             frames_sent, timing_sets, reg_writes);
    $display("Checked %0d result beats, %0d of them wrong.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
